// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files that check themselves
// no dependencies; clock and reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SCP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// consequent must hold in the cycle after the antecedent
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/scp_pkg.sv -----
// shared types, constants and helpers for the setpoint command line parser
// no dependencies; used by all rtl modules through scoped names
`timescale 1ns / 1ps

package scp_pkg;

	localparam int LINE_CHARS = 15;
	localparam int POS_W      = $clog2(LINE_CHARS + 1);
	localparam int CHAR_W     = 8;
	localparam int VAL_W      = 16;
	localparam int WIDE_W     = VAL_W + 4;
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 1;

	// prefix "SP:" fills positions 0..2, shortest valid line is four chars
	localparam int PREFIX_CHARS = 3;
	localparam int SHORT_LINE   = 4;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	// result status codes
	localparam logic [ST_W-1:0] ST_SET     = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
	localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd3;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LO = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HI = 1'b1;
	localparam logic [VAL_W-1:0]     MIN_RESET    = 16'd100;
	localparam logic [VAL_W-1:0]     MAX_RESET    = 16'd500;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_S_UC  = 8'h53;
	localparam logic [CHAR_W-1:0] CH_S_LC  = 8'h73;
	localparam logic [CHAR_W-1:0] CH_P_UC  = 8'h50;
	localparam logic [CHAR_W-1:0] CH_P_LC  = 8'h70;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// line summary handed from the parser to the limit check
	typedef struct packed {
		logic             eol;
		logic             fire;
		logic             unknown;
		logic             bad_num;
		logic [VAL_W-1:0] value;
	} scp_line_res_t;

	// times ten by shift and add
	function automatic logic [WIDE_W-1:0] times10(input logic [VAL_W-1:0] a);
		logic [WIDE_W-1:0] w;
		w = {4'b0000, a};
		return (w << 3) + (w << 1);
	endfunction

	// clamp a widened sum to the 16 bit range
	function automatic logic [VAL_W-1:0] sat16(input logic [WIDE_W-1:0] w);
		return (w > {4'b0000, VAL_MAX}) ? VAL_MAX : w[VAL_W-1:0];
	endfunction

endpackage

// ----- rtl/scp_line_parser.sv -----
// per-line parse state: prefix check, integer and decimal digit accumulation
// depends on scp_pkg
`timescale 1ns / 1ps

module scp_line_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [scp_pkg::CHAR_W-1:0]  in_char,
	output scp_pkg::scp_line_res_t      res
);

	logic [scp_pkg::POS_W-1:0]  pos_q, pos_d;
	logic                       prefix_bad_q, prefix_bad_d;
	logic [scp_pkg::VAL_W-1:0]  acc_q, acc_d;
	logic                       seen_point_q, seen_point_d;
	logic [3:0]                 frac_q, frac_d;
	logic                       frac_taken_q, frac_taken_d;
	logic                       number_bad_q, number_bad_d;

	logic                       is_eol;
	logic                       is_digit;
	logic [3:0]                 digit;
	logic [scp_pkg::WIDE_W-1:0] acc_x10;
	logic [scp_pkg::WIDE_W-1:0] acc_next;
	logic [scp_pkg::WIDE_W-1:0] final_sum;

	assign is_eol   = (in_char == scp_pkg::CH_LF) || (in_char == scp_pkg::CH_CR);
	assign is_digit = (in_char >= scp_pkg::CH_ZERO) && (in_char <= scp_pkg::CH_NINE);
	assign digit    = in_char[3:0];
	assign acc_x10  = scp_pkg::times10(acc_q);
	assign acc_next = acc_x10 + {{(scp_pkg::WIDE_W-4){1'b0}}, digit};
	assign final_sum = acc_x10 + {{(scp_pkg::WIDE_W-4){1'b0}}, frac_q};

	always_comb begin
		pos_d        = pos_q;
		prefix_bad_d = prefix_bad_q;
		acc_d        = acc_q;
		seen_point_d = seen_point_q;
		frac_d       = frac_q;
		frac_taken_d = frac_taken_q;
		number_bad_d = number_bad_q;
		if (step) begin
			if (is_eol) begin
				pos_d        = '0;
				prefix_bad_d = 1'b0;
				acc_d        = '0;
				seen_point_d = 1'b0;
				frac_d       = '0;
				frac_taken_d = 1'b0;
				number_bad_d = 1'b0;
			end else if (pos_q < scp_pkg::POS_W'(scp_pkg::LINE_CHARS)) begin
				pos_d = pos_q + 1'b1;
				if (pos_q == scp_pkg::POS_W'(0)) begin
					if (in_char != scp_pkg::CH_S_UC && in_char != scp_pkg::CH_S_LC)
						prefix_bad_d = 1'b1;
				end else if (pos_q == scp_pkg::POS_W'(1)) begin
					if (in_char != scp_pkg::CH_P_UC && in_char != scp_pkg::CH_P_LC)
						prefix_bad_d = 1'b1;
				end else if (pos_q == scp_pkg::POS_W'(scp_pkg::PREFIX_CHARS - 1)) begin
					if (in_char != scp_pkg::CH_COLON)
						prefix_bad_d = 1'b1;
				end else if (!number_bad_q && !frac_taken_q) begin
					if (is_digit) begin
						if (!seen_point_q) begin
							acc_d = scp_pkg::sat16(acc_next);
						end else begin
							frac_d       = digit;
							frac_taken_d = 1'b1;
						end
					end else if (in_char == scp_pkg::CH_POINT && !seen_point_q) begin
						seen_point_d = 1'b1;
					end else begin
						number_bad_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			prefix_bad_q <= 1'b0;
			acc_q        <= '0;
			seen_point_q <= 1'b0;
			frac_q       <= '0;
			frac_taken_q <= 1'b0;
			number_bad_q <= 1'b0;
		end else begin
			pos_q        <= pos_d;
			prefix_bad_q <= prefix_bad_d;
			acc_q        <= acc_d;
			seen_point_q <= seen_point_d;
			frac_q       <= frac_d;
			frac_taken_q <= frac_taken_d;
			number_bad_q <= number_bad_d;
		end
	end

	// summary of the line as it stands, valid when the current char ends it
	always_comb begin
		res.eol     = is_eol;
		res.fire    = is_eol && (pos_q != '0);
		res.unknown = prefix_bad_q || (pos_q < scp_pkg::POS_W'(scp_pkg::SHORT_LINE));
		res.bad_num = number_bad_q;
		res.value   = scp_pkg::sat16(final_sum);
	end

endmodule

// ----- rtl/scp_limit_check.sv -----
// turns a finished line summary into status and reported value
// depends on scp_pkg
`timescale 1ns / 1ps

module scp_limit_check (
	input  scp_pkg::scp_line_res_t      res,
	input  logic [scp_pkg::VAL_W-1:0]   lo_limit,
	input  logic [scp_pkg::VAL_W-1:0]   hi_limit,
	output logic [scp_pkg::ST_W-1:0]    status,
	output logic [scp_pkg::VAL_W-1:0]   value_tenths
);

	logic in_range;

	assign in_range = (res.value >= lo_limit) && (res.value <= hi_limit);

	always_comb begin
		if (res.unknown) begin
			status       = scp_pkg::ST_UNKNOWN;
			value_tenths = '0;
		end else if (res.bad_num) begin
			status       = scp_pkg::ST_INVALID;
			value_tenths = '0;
		end else begin
			status       = in_range ? scp_pkg::ST_SET : scp_pkg::ST_RANGE;
			value_tenths = res.value;
		end
	end

endmodule

// ----- rtl/setpoint_command_line_parser_top.sv -----
// top level of the setpoint command line parser: input register, config, result register
// depends on scp_pkg, scp_line_parser, scp_limit_check and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one ASCII character per beat and parses lines of the form SP:<digits>[.<digit>]
// (prefix case-insensitive) into tenths. A CR or LF that ends a non-empty line gives one
// result beat: status 0 set, 1 out of range, 2 invalid number, 3 unknown command, with
// value_tenths saturated at 65535 and zero for an invalid number or unknown command.
// Only the first 15 characters of a line count; empty lines give nothing, so CR LF gives
// one result. Throughput is one character per clock: a character is captured in the input
// register and folded into the line state from there, while a finished result sits
// in the output register. The only stall is a line terminator reaching the parse stage
// while the output register still holds an untaken result; it then waits there and holds
// off the input (characters that do not end a line never wait on the output). The result
// register is loaded as the terminator is folded in. The low limit (index 0, reset
// 100) and the high limit (index 1, reset 500) are written through the cfg port, which is
// always ready; write them only while idle.

module setpoint_command_line_parser_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// character input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [scp_pkg::CHAR_W-1:0]        in_char,
	// result output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [scp_pkg::ST_W-1:0]          status,
	output logic [scp_pkg::VAL_W-1:0]         value_tenths,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [scp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scp_pkg::VAL_W-1:0]         cfg_data
);

	// input register
	logic                        valid_s1;
	logic [scp_pkg::CHAR_W-1:0]  char_s1;

	// limits
	logic [scp_pkg::VAL_W-1:0]   min_q;
	logic [scp_pkg::VAL_W-1:0]   max_q;

	// result register
	logic                        out_valid_q;
	logic [scp_pkg::ST_W-1:0]    status_q;
	logic [scp_pkg::VAL_W-1:0]   value_q;

	scp_pkg::scp_line_res_t      line_res;
	logic [scp_pkg::ST_W-1:0]    status_d;
	logic [scp_pkg::VAL_W-1:0]   value_d;
	logic                        out_free;
	logic                        step;
	logic                        load_out;

	// terms for the checks at the end
	logic                        out_rejected;
	logic                        out_set;
	logic                        eol_blocked;

	// output slot is free if empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// only a terminator needs the result slot
	assign step     = valid_s1 && (!line_res.eol || out_free);
	assign load_out = step && line_res.fire;
	assign in_ready = !valid_s1 || step;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign value_tenths = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= scp_pkg::MIN_RESET;
			max_q <= scp_pkg::MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				scp_pkg::REG_LIMIT_LO: min_q <= cfg_data;
				scp_pkg::REG_LIMIT_HI: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	scp_line_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_char (char_s1),
		.res     (line_res)
	);

	scp_limit_check u_limits (
		.res          (line_res),
		.lo_limit     (min_q),
		.hi_limit     (max_q),
		.status       (status_d),
		.value_tenths (value_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_d;
			value_q  <= value_d;
		end
	end

	assign out_rejected = out_valid_q &&
		(status_q == scp_pkg::ST_UNKNOWN || status_q == scp_pkg::ST_INVALID);
	assign out_set      = out_valid_q && (status_q == scp_pkg::ST_SET);
	assign eol_blocked  = valid_s1 && line_res.eol && !out_free;

	// rejected or unknown lines never carry a value
	`SCP_ASSERT_SAME(a_zero_value_on_reject, clk, arst_n, out_rejected, value_q == '0)

	// a reported set lies inside the current limits
	`SCP_ASSERT_SAME(a_set_within_limits, clk, arst_n, out_set, value_q >= min_q && value_q <= max_q)

	// a terminator blocked by a full result slot waits in the input register
	`SCP_ASSERT_NEXT(a_eol_held, clk, arst_n, eol_blocked, valid_s1 && $stable(char_s1))

	// the result slot is never overwritten while still owed downstream
	`SCP_ASSERT_SAME(a_no_overwrite, clk, arst_n, load_out, out_free)

endmodule
